// ----- rtl/mclp_pkg.sv -----
// shared types and constants for the motor command line parser
package mclp_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int MUL_WIDTH   = VALUE_WIDTH + 4;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic STATUS_ACCEPT = 1'b0;
  localparam logic STATUS_BAD    = 1'b1;

  typedef struct packed {
    logic                          status;
    logic [1:0]                    fields_updated;
    logic signed [VALUE_WIDTH-1:0] thrust_value;
    logic signed [VALUE_WIDTH-1:0] rudder_value;
  } mclp_result_t;

endpackage

// ----- rtl/motor_command_line_parser.sv -----
// top level: input byte register, parse core and result register
//
// Receives serial characters on the in_ channel, one byte per beat. A line
// ends with '#'; a line that held an 'M' produces one beat on the out_
// channel with status, fields_updated and the held thrust and rudder values.
// Lines without an 'M' produce nothing.
//
// A byte accepted into the input byte register is parsed when it moves on;
// its result (if any) is captured in the result register that drives out_.
// Throughput: one byte per cycle unless a result waits on a stalled receiver,
// set by the combinational parse step between the input and result registers.
//
// Reset (rst_n low, synchronous) returns the parser to scanning for 'M',
// clears held thrust and rudder to zero and drops both valid flags.
//
// When the receiver stalls with a result pending, bytes that end no line
// keep flowing; a '#' that would give a new result waits in the input
// register, and in_ready drops until out_ready frees the result register.
module motor_command_line_parser import mclp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [1:0]                    out_fields_updated,
  output logic signed [VALUE_WIDTH-1:0] out_thrust_value,
  output logic signed [VALUE_WIDTH-1:0] out_rudder_value
);

  logic [7:0]   byte_r;
  logic         byte_valid_r, byte_valid_nxt;
  logic         out_valid_r, out_valid_nxt;
  mclp_result_t res_r;
  mclp_result_t core_res;
  logic         core_emit;
  logic         advance;
  logic         in_fire;

  mclp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .rx_byte (byte_r),
    .emit    (core_emit),
    .result  (core_res)
  );

  // a byte moves into the parser unless its result has nowhere to go
  assign advance  = byte_valid_r && (!core_emit || !out_valid_r || out_ready);
  assign in_ready = !byte_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  assign byte_valid_nxt = in_fire ? 1'b1 : (advance ? 1'b0 : byte_valid_r);
  assign out_valid_nxt  = (advance && core_emit) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_valid_r <= byte_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) byte_r <= in_rx_byte;
    if (advance && core_emit) res_r <= core_res;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_fields_updated = res_r.fields_updated;
  assign out_thrust_value   = res_r.thrust_value;
  assign out_rudder_value   = res_r.rudder_value;

endmodule

// ----- rtl/mclp_core.sv -----
// byte-level parse state machine and held thrust/rudder values
module mclp_core import mclp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_en,
  input  logic [7:0]   rx_byte,
  output logic         emit,
  output mclp_result_t result
);

  localparam logic [3:0] PH_SCAN    = 4'd0;
  localparam logic [3:0] PH_AFTER_M = 4'd1;
  localparam logic [3:0] PH_N1_WS   = 4'd2;
  localparam logic [3:0] PH_N1_SIGN = 4'd3;
  localparam logic [3:0] PH_N1_DIG  = 4'd4;
  localparam logic [3:0] PH_N2_WS   = 4'd5;
  localparam logic [3:0] PH_N2_SIGN = 4'd6;
  localparam logic [3:0] PH_N2_DIG  = 4'd7;
  localparam logic [3:0] PH_SKIP    = 4'd8;

  localparam logic [1:0] OUT_NONE   = 2'd0;
  localparam logic [1:0] OUT_ACCEPT = 2'd1;
  localparam logic [1:0] OUT_BAD    = 2'd2;

  localparam logic [MUL_WIDTH-1:0]   ACC_LIM   = MUL_WIDTH'(1) << (VALUE_WIDTH - 1);
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = ACC_LIM[VALUE_WIDTH-1:0] - VALUE_WIDTH'(1);

  logic [3:0]                    phase_r, phase_pre, phase_nxt;
  logic [1:0]                    outcome_r, outcome_pre, outcome_nxt;
  logic [1:0]                    count_r, count_pre, count_nxt;
  logic [VALUE_WIDTH-1:0]        acc_r, acc_pre, acc_nxt;
  logic                          neg_r, neg_pre, neg_nxt;
  logic signed [VALUE_WIDTH-1:0] thrust_r, thrust_nxt;
  logic signed [VALUE_WIDTH-1:0] rudder_r, rudder_nxt;

  logic                          is_hash, is_ws, is_digit, is_sign;
  logic [MUL_WIDTH-1:0]          acc_mul;
  logic [VALUE_WIDTH-1:0]        acc_sat;
  logic signed [VALUE_WIDTH-1:0] finished;
  logic                          line_end;

  assign is_hash  = (rx_byte == CH_HASH);
  assign is_ws    = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);

  // acc * 10 + digit, saturating at the magnitude of the most negative value
  assign acc_mul = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
                 + {{(MUL_WIDTH-4){1'b0}}, rx_byte[3:0]};
  assign acc_sat = (acc_mul > ACC_LIM) ? ACC_LIM[VALUE_WIDTH-1:0] : acc_mul[VALUE_WIDTH-1:0];

  assign finished = neg_r ? -$signed(acc_r)
                          : $signed((acc_r > VALUE_MAX) ? VALUE_MAX : acc_r);

  always_comb begin
    phase_pre   = phase_r;
    outcome_pre = outcome_r;
    count_pre   = count_r;
    acc_pre     = acc_r;
    neg_pre     = neg_r;
    thrust_nxt  = thrust_r;
    rudder_nxt  = rudder_r;
    line_end    = 1'b0;
    unique case (phase_r)
      PH_SCAN: begin
        if (is_hash) line_end = 1'b1;
        else if (rx_byte == CH_M) phase_pre = PH_AFTER_M;
      end
      PH_AFTER_M: begin
        count_pre = 2'd0;
        if (rx_byte == CH_EQ) begin
          outcome_pre = OUT_ACCEPT;
          acc_pre     = '0;
          neg_pre     = 1'b0;
          phase_pre   = PH_N1_WS;
        end else begin
          outcome_pre = OUT_BAD;
          if (is_hash) line_end = 1'b1;
          else phase_pre = PH_SKIP;
        end
      end
      PH_N1_WS, PH_N2_WS: begin
        if (is_hash) line_end = 1'b1;
        else if (is_ws) phase_pre = phase_r;
        else if (is_sign) begin
          neg_pre   = (rx_byte == CH_MINUS);
          phase_pre = (phase_r == PH_N1_WS) ? PH_N1_SIGN : PH_N2_SIGN;
        end else if (is_digit) begin
          acc_pre   = acc_sat;
          phase_pre = (phase_r == PH_N1_WS) ? PH_N1_DIG : PH_N2_DIG;
        end else phase_pre = PH_SKIP;
      end
      PH_N1_SIGN, PH_N2_SIGN: begin
        if (is_hash) line_end = 1'b1;
        else if (is_digit) begin
          acc_pre   = acc_sat;
          phase_pre = (phase_r == PH_N1_SIGN) ? PH_N1_DIG : PH_N2_DIG;
        end else phase_pre = PH_SKIP;
      end
      PH_N1_DIG: begin
        if (is_digit) acc_pre = acc_sat;
        else begin
          thrust_nxt = finished;
          count_pre  = 2'd1;
          if (is_hash) line_end = 1'b1;
          else if (rx_byte == CH_COMMA) begin
            acc_pre   = '0;
            neg_pre   = 1'b0;
            phase_pre = PH_N2_WS;
          end else phase_pre = PH_SKIP;
        end
      end
      PH_N2_DIG: begin
        if (is_digit) acc_pre = acc_sat;
        else begin
          rudder_nxt = finished;
          count_pre  = 2'd2;
          if (is_hash) line_end = 1'b1;
          else phase_pre = PH_SKIP;
        end
      end
      default: begin
        // skip phase and unused codes
        if (is_hash) line_end = 1'b1;
        else phase_pre = PH_SKIP;
      end
    endcase
  end

  assign emit                  = line_end && (outcome_pre != OUT_NONE);
  assign result.status         = (outcome_pre == OUT_BAD) ? STATUS_BAD : STATUS_ACCEPT;
  assign result.fields_updated = count_pre;
  assign result.thrust_value   = thrust_nxt;
  assign result.rudder_value   = rudder_nxt;

  // end of line returns to scanning, held values stay
  assign phase_nxt   = line_end ? PH_SCAN  : phase_pre;
  assign outcome_nxt = line_end ? OUT_NONE : outcome_pre;
  assign count_nxt   = line_end ? 2'd0     : count_pre;
  assign acc_nxt     = line_end ? '0       : acc_pre;
  assign neg_nxt     = line_end ? 1'b0     : neg_pre;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SCAN;
      outcome_r <= OUT_NONE;
      count_r   <= 2'd0;
      acc_r     <= '0;
      neg_r     <= 1'b0;
      thrust_r  <= '0;
      rudder_r  <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      outcome_r <= outcome_nxt;
      count_r   <= count_nxt;
      acc_r     <= acc_nxt;
      neg_r     <= neg_nxt;
      thrust_r  <= thrust_nxt;
      rudder_r  <= rudder_nxt;
    end
  end

endmodule

// ----- tb/sv/motor_command_line_parser_test.sv -----
// self-checking bench for the motor command line parser: random lines, stalls and a scoreboard
module motor_command_line_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mclp_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int MAG_LIMIT    = 1 << (VALUE_WIDTH - 1);
  localparam int RANDOM_BYTES = 1050;

  typedef enum logic [3:0] {
    WAIT_M, GOT_M, A_SPACE, A_SIGN, A_DIGITS, B_SPACE, B_SIGN, B_DIGITS, DISCARD
  } scan_phase_t;

  typedef enum logic [1:0] {NO_CMD, CMD_OK, CMD_BAD} line_kind_t;

  typedef struct {
    logic [7:0]  rx;
    int unsigned gap;
    bit          hold;
  } tx_beat_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_rx_byte = 8'h00;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_status;
  logic [1:0]                    out_fields_updated;
  logic signed [VALUE_WIDTH-1:0] out_thrust_value;
  logic signed [VALUE_WIDTH-1:0] out_rudder_value;

  // parser image
  scan_phase_t                   scan_phase = WAIT_M;
  line_kind_t                    cmd_kind = NO_CMD;
  logic signed [VALUE_WIDTH-1:0] thrust_q = '0;
  logic signed [VALUE_WIDTH-1:0] rudder_q = '0;
  int                            mag = 0;
  bit                            mag_neg = 1'b0;
  logic [1:0]                    stored = 2'd0;

  tx_beat_t     tx_bytes[$];
  mclp_result_t line_reports_q[$];
  mclp_result_t next_report;
  mclp_result_t want;
  tx_beat_t     cur;

  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  bit noisy = 1'b0;
  bit hold_next = 1'b0;
  int wait_left = 0;
  int rx_wait = 0;
  int n_directed = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int reports_seen = 0;
  int bad_seen = 0;
  int values_stored = 0;
  int mismatches = 0;

  motor_command_line_parser u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_fields_updated (out_fields_updated),
    .out_thrust_value   (out_thrust_value),
    .out_rudder_value   (out_rudder_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void add_digit(input logic [7:0] c);
    int v;
    v = mag * 10 + (int'(c) - int'(CH_ZERO));
    mag = (v > MAG_LIMIT) ? MAG_LIMIT : v;
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] settled_value();
    int m;
    m = mag;
    if (mag_neg) return VALUE_WIDTH'(-m);
    if (m > MAG_LIMIT - 1) m = MAG_LIMIT - 1;
    return VALUE_WIDTH'(m);
  endfunction

  // advances the parser image by one byte; returns 1 when the line closes with a report
  function automatic bit parse_byte(input logic [7:0] c, output mclp_result_t rep);
    bit hash, is_ws, is_dig, close_now, got;
    hash = (c == CH_HASH);
    is_ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    close_now = 1'b0;
    got = 1'b0;
    rep = '0;
    case (scan_phase)
      WAIT_M: begin
        if (hash) close_now = 1'b1;
        else if (c == CH_M) scan_phase = GOT_M;
      end
      GOT_M: begin
        stored = 2'd0;
        if (c == CH_EQ) begin
          cmd_kind = CMD_OK;
          mag = 0;
          mag_neg = 1'b0;
          scan_phase = A_SPACE;
        end else begin
          cmd_kind = CMD_BAD;
          if (hash) close_now = 1'b1;
          else scan_phase = DISCARD;
        end
      end
      A_SPACE, B_SPACE: begin
        if (hash) begin
          close_now = 1'b1;
        end else if (is_ws) begin
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          mag_neg = (c == CH_MINUS);
          scan_phase = (scan_phase == A_SPACE) ? A_SIGN : B_SIGN;
        end else if (is_dig) begin
          add_digit(c);
          scan_phase = (scan_phase == A_SPACE) ? A_DIGITS : B_DIGITS;
        end else begin
          scan_phase = DISCARD;
        end
      end
      A_SIGN, B_SIGN: begin
        if (hash) begin
          close_now = 1'b1;
        end else if (is_dig) begin
          add_digit(c);
          scan_phase = (scan_phase == A_SIGN) ? A_DIGITS : B_DIGITS;
        end else begin
          scan_phase = DISCARD;
        end
      end
      A_DIGITS: begin
        if (is_dig) begin
          add_digit(c);
        end else begin
          thrust_q = settled_value();
          stored = 2'd1;
          if (hash) begin
            close_now = 1'b1;
          end else if (c == CH_COMMA) begin
            mag = 0;
            mag_neg = 1'b0;
            scan_phase = B_SPACE;
          end else begin
            scan_phase = DISCARD;
          end
        end
      end
      B_DIGITS: begin
        if (is_dig) begin
          add_digit(c);
        end else begin
          rudder_q = settled_value();
          stored = 2'd2;
          if (hash) close_now = 1'b1;
          else scan_phase = DISCARD;
        end
      end
      default: begin
        if (hash) close_now = 1'b1;
        else scan_phase = DISCARD;
      end
    endcase
    if (close_now) begin
      if (cmd_kind != NO_CMD) begin
        got = 1'b1;
        rep.status = (cmd_kind == CMD_BAD) ? STATUS_BAD : STATUS_ACCEPT;
        rep.fields_updated = stored;
        rep.thrust_value = thrust_q;
        rep.rudder_value = rudder_q;
      end
      scan_phase = WAIT_M;
      cmd_kind = NO_CMD;
      stored = 2'd0;
      mag = 0;
      mag_neg = 1'b0;
    end
    return got;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    tx_beat_t beat;
    beat.rx = b;
    beat.gap = tx_fast ? 0 : $urandom_range(0, 14);
    beat.hold = hold_next;
    hold_next = 1'b0;
    tx_bytes.push_back(beat);
    // stray byte dropped into an otherwise clean line
    if (noisy && $urandom_range(0, 19) == 0) begin
      beat.rx = 8'($urandom_range(0, 255));
      beat.hold = 1'b0;
      tx_bytes.push_back(beat);
    end
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] ws_byte();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
  endfunction

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_M || b == CH_HASH);
    return b;
  endfunction

  function automatic void push_number();
    int n;
    n = 0;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_byte(ws_byte());
    case ($urandom_range(0, 3))
      0: push_byte(CH_MINUS);
      1: push_byte(CH_PLUS);
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: push_text("32767");
      1: push_text("32768");
      2: n = $urandom_range(6, 9);
      default: n = $urandom_range(1, 5);
    endcase
    repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void push_line();
    int kind;
    kind = $urandom_range(0, 99);
    noisy = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 9) == 0) tx_fast = !tx_fast;
    if ($urandom_range(0, 49) == 0) hold_next = 1'b1;
    if (kind < 70 && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) push_byte(junk_byte());
    if (kind < 60) begin
      push_byte(CH_M);
      push_byte(CH_EQ);
      push_number();
      push_byte(CH_COMMA);
      push_number();
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) push_byte(junk_byte());
    end else if (kind < 70) begin
      push_byte(CH_M);
      push_byte(CH_EQ);
      push_number();
      case ($urandom_range(0, 2))
        0: ;
        1: push_text(", ");
        default: begin
          push_byte(ws_byte());
          push_byte(CH_COMMA);
          push_number();
        end
      endcase
    end else if (kind < 80) begin
      push_byte(CH_M);
      repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)));
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 6)) push_byte(junk_byte());
    end
    push_byte(CH_HASH);
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (parse_byte(in_rx_byte, next_report)) line_reports_q.push_back(next_report);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (wait_left > 0) begin
          wait_left--;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() == 0 ||
                     (tx_bytes[0].hold && line_reports_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          cur = tx_bytes.pop_front();
          in_valid <= 1'b1;
          in_rx_byte <= cur.rx;
          wait_left = (tx_bytes.size() != 0) ? tx_bytes[0].gap : 0;
        end
      end
    end
  end

  // receiver and scoreboard
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (line_reports_q.size() == 0) begin
          $display("%0t ns: unexpected report status %0d fields %0d thrust %0d rudder %0d",
                   $time, out_status, out_fields_updated, out_thrust_value, out_rudder_value);
          mismatches++;
        end else begin
          want = line_reports_q.pop_front();
          reports_seen++;
          if (want.status == STATUS_BAD) bad_seen++;
          values_stored += want.fields_updated;
          if (out_status !== want.status) begin
            $display("%0t ns: status expected %0d got %0d", $time, want.status, out_status);
            mismatches++;
          end
          if (out_fields_updated !== want.fields_updated) begin
            $display("%0t ns: fields_updated expected %0d got %0d",
                     $time, want.fields_updated, out_fields_updated);
            mismatches++;
          end
          if (out_thrust_value !== want.thrust_value) begin
            $display("%0t ns: thrust expected %0d got %0d",
                     $time, want.thrust_value, out_thrust_value);
            mismatches++;
          end
          if (out_rudder_value !== want.rudder_value) begin
            $display("%0t ns: rudder expected %0d got %0d",
                     $time, want.rudder_value, out_rudder_value);
            mismatches++;
          end
        end
        if ($urandom_range(0, 7) == 0) rx_fast = !rx_fast;
        rx_wait = rx_fast ? 0 : $urandom_range(0, 14);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles, line_reports_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // junk before the command, sign, negative overflow, second command letter
    push_text("xM=-40000,7M#");
    // leading space, positive overflow, first number ended by the line end
    push_text("M= 99999#");
    push_text("M#");
    push_text("#");
    push_byte(8'hFF);
    push_byte(8'h00);
    // sign with no digit
    push_text("M=+#");
    n_directed = tx_bytes.size();
    hold_next = 1'b1;
    while (tx_bytes.size() < n_directed + RANDOM_BYTES) push_line();

    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (tx_bytes.size() != 0 || in_valid) @(negedge clk);
    while (line_reports_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (line_reports_q.size() != 0) begin
      $display("%0t ns: %0d reports never arrived", $time, line_reports_q.size());
      mismatches++;
    end
    $display("%0d bytes in, %0d command lines reported (%0d bad parses, %0d numbers stored)",
             bytes_sent, reports_seen, bad_seen, values_stored);
    $display("%0d field mismatches over %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- motor_command_line_parser.f -----
rtl/mclp_pkg.sv
rtl/mclp_core.sv
rtl/motor_command_line_parser.sv
tb/sv/motor_command_line_parser_test.sv
